// ===== rtl/ogbu_pkg.sv =====
// ----------------------------------------------------------------------------
// ogbu_pkg
// Shared constants, types and register codes for the occupancy grid update.
// ----------------------------------------------------------------------------
package ogbu_pkg;

  localparam int GRID_CELLS = 65536;
  localparam int ADDR_W     = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;

  localparam int IDX_W     = 16;
  localparam int COST_W    = 8;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [COST_W-1:0] COST_FREE    = 8'd0;
  localparam logic [COST_W-1:0] COST_LETHAL  = 8'd254;
  localparam logic [COST_W-1:0] COST_UNKNOWN = 8'd255;
  localparam logic [COST_W-1:0] COST_MIN     = 8'd1;
  localparam logic [COST_W-1:0] COST_MAX     = 8'd254;

  localparam logic [CFG_W-1:0] RST_P_OCC_OCC        = 16'd62259;
  localparam logic [CFG_W-1:0] RST_P_OCC_FREE_PRIOR = 16'd26214;
  localparam logic [CFG_W-1:0] RST_P_FREE_FREE      = 16'd39322;
  localparam logic [CFG_W-1:0] RST_P_FREE_OCC_PRIOR = 16'd3277;
  localparam logic [CFG_W-1:0] RST_DECAY_BIAS       = 16'd32640;
  localparam logic [CFG_W-1:0] RST_DECAY_GAIN       = 16'd32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_P_OCC_OCC        = 3'd0,
    REG_P_OCC_FREE_PRIOR = 3'd1,
    REG_P_FREE_FREE      = 3'd2,
    REG_P_FREE_OCC_PRIOR = 3'd3,
    REG_DECAY_BIAS       = 3'd4,
    REG_DECAY_GAIN       = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_BLEND,
    MODE_DECAY,
    MODE_ZERO
  } mode_t;

  typedef struct packed {
    logic [CFG_W-1:0] p_occ_given_occ;
    logic [CFG_W-1:0] p_occ_given_free_prior;
    logic [CFG_W-1:0] p_free_given_free;
    logic [CFG_W-1:0] p_free_given_occ_prior;
    logic [CFG_W-1:0] decay_bias;
    logic [CFG_W-1:0] decay_gain;
  } cfg_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } ram_rd_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [COST_W-1:0] data;
  } ram_wr_t;

endpackage

// ===== rtl/ogbu_in_if.sv =====
// ----------------------------------------------------------------------------
// ogbu_in_if
// Measurement channel: one beat names a cell and its single-frame cost.
// ----------------------------------------------------------------------------
interface ogbu_in_if;
  import ogbu_pkg::*;

  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  cell_index;
  logic [COST_W-1:0] measurement;

  modport source (output valid, cell_index, measurement, input ready);
  modport sink   (input valid, cell_index, measurement, output ready);
endinterface

// ===== rtl/ogbu_out_if.sv =====
// ----------------------------------------------------------------------------
// ogbu_out_if
// Result channel: one beat carries the updated cell and its new cost.
// ----------------------------------------------------------------------------
interface ogbu_out_if;
  import ogbu_pkg::*;

  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  cell_out;
  logic [COST_W-1:0] new_cost;

  modport source (output valid, cell_out, new_cost, input ready);
  modport sink   (input valid, cell_out, new_cost, output ready);
endinterface

// ===== rtl/occupancy_grid_bayes_update_top.sv =====
// ----------------------------------------------------------------------------
// occupancy_grid_bayes_update_top
// Binary Bayes filter update of an 8-bit occupancy grid held in block RAM.
// Throughput: one beat per cycle while the result channel does not stall; a cell
// still in the three compute stages holds off a new beat for that cell until
// its write-back.
// Reset: synchronous; afterwards a fill pass writes unknown (255) to every
// one of the GRID_CELLS (65536) cells, while no measurement beat is taken.
// ----------------------------------------------------------------------------
module occupancy_grid_bayes_update_top (
  input  logic                           clk,
  input  logic                           rst,
  ogbu_in_if.sink                        sample,
  ogbu_out_if.source                     result,
  input  logic                           cfg_we,
  input  logic [ogbu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ogbu_pkg::CFG_W-1:0]     cfg_data
);
  import ogbu_pkg::*;

  cfg_t              cfg;
  ram_rd_t           rd;
  ram_wr_t           wr;
  logic [COST_W-1:0] rd_data;

  logic              clearing;
  logic [ADDR_W-1:0] clr_addr;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [COST_W-1:0] ram_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == ADDR_W'(GRID_CELLS - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  assign ram_we    = clearing ? 1'b1 : wr.en;
  assign ram_waddr = clearing ? clr_addr : wr.addr;
  assign ram_wdata = clearing ? COST_UNKNOWN : wr.data;

  ogbu_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ogbu_ram #(
    .WIDTH (COST_W),
    .DEPTH (GRID_CELLS)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (rd.en),
    .raddr (rd.addr),
    .rdata (rd_data)
  );

  ogbu_pipe u_pipe (
    .clk      (clk),
    .rst      (rst),
    .clearing (clearing),
    .cfg      (cfg),
    .sample   (sample),
    .result   (result),
    .rd       (rd),
    .rd_data  (rd_data),
    .wr       (wr)
  );

endmodule

// ===== rtl/ogbu_ram.sv =====
// ----------------------------------------------------------------------------
// ogbu_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ogbu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/ogbu_cfg.sv =====
// ----------------------------------------------------------------------------
// ogbu_cfg
// Register file for the transition weights and decay coefficients.
// ----------------------------------------------------------------------------
module ogbu_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ogbu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ogbu_pkg::CFG_W-1:0]     cfg_data,
  output ogbu_pkg::cfg_t                cfg
);
  import ogbu_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.p_occ_given_occ        <= RST_P_OCC_OCC;
      cfg.p_occ_given_free_prior <= RST_P_OCC_FREE_PRIOR;
      cfg.p_free_given_free      <= RST_P_FREE_FREE;
      cfg.p_free_given_occ_prior <= RST_P_FREE_OCC_PRIOR;
      cfg.decay_bias             <= RST_DECAY_BIAS;
      cfg.decay_gain             <= RST_DECAY_GAIN;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_P_OCC_OCC:        cfg.p_occ_given_occ        <= cfg_data;
        REG_P_OCC_FREE_PRIOR: cfg.p_occ_given_free_prior <= cfg_data;
        REG_P_FREE_FREE:      cfg.p_free_given_free      <= cfg_data;
        REG_P_FREE_OCC_PRIOR: cfg.p_free_given_occ_prior <= cfg_data;
        REG_DECAY_BIAS:       cfg.decay_bias             <= cfg_data;
        REG_DECAY_GAIN:       cfg.decay_gain             <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/ogbu_pipe.sv =====
// ----------------------------------------------------------------------------
// ogbu_pipe
// Update pipeline: prior fetch, weighted products, sums and decay product,
// clamp and write-back, then the output register.
// ----------------------------------------------------------------------------
module ogbu_pipe (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        clearing,
  input  ogbu_pkg::cfg_t              cfg,
  ogbu_in_if.sink                     sample,
  ogbu_out_if.source                  result,
  output ogbu_pkg::ram_rd_t           rd,
  input  logic [ogbu_pkg::COST_W-1:0] rd_data,
  output ogbu_pkg::ram_wr_t           wr
);
  import ogbu_pkg::*;

  logic adv;
  logic hazard;
  logic acc;
  logic inside_in;

  // stage 1: prior arrives from the RAM
  logic              v1;
  logic              in1;
  logic [IDX_W-1:0]  idx1;
  logic [COST_W-1:0] z1;
  logic [COST_W-1:0] prior1;
  logic [COST_W-1:0] not_prior1;
  logic [CFG_W-1:0]  wa1;
  logic [CFG_W-1:0]  wb1;
  mode_t             mode1;
  logic [23:0]       pa1;
  logic [23:0]       pb1;
  logic [16:0]       num1;

  // stage 2
  logic              v2;
  logic              in2;
  logic [IDX_W-1:0]  idx2;
  mode_t             mode2;
  logic [23:0]       pa2;
  logic [23:0]       pb2;
  logic [16:0]       num2;
  logic [23:0]       sum2;
  logic [32:0]       dprod2;

  // stage 3
  logic              v3;
  logic              in3;
  logic [IDX_W-1:0]  idx3;
  mode_t             mode3;
  logic [7:0]        blend3;
  logic [8:0]        decay3;
  logic [8:0]        est3;
  logic [COST_W-1:0] cost3;

  // output register
  logic              ov;
  logic [IDX_W-1:0]  out_idx;
  logic [COST_W-1:0] out_cost;

  assign adv = !ov || result.ready;

  // a cell still in flight has not been written back yet
  assign hazard = (v1 && in1 && idx1 == sample.cell_index) ||
                  (v2 && in2 && idx2 == sample.cell_index) ||
                  (v3 && in3 && idx3 == sample.cell_index);

  assign sample.ready = !clearing && adv && !hazard;
  assign acc          = sample.valid && sample.ready;
  assign inside_in    = 32'(sample.cell_index) < 32'(GRID_CELLS);

  assign rd.en   = acc && inside_in;
  assign rd.addr = ADDR_W'(sample.cell_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      ov <= 1'b0;
    end else if (adv) begin
      v1 <= acc;
      v2 <= v1;
      v3 <= v2;
      ov <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (acc) begin
        idx1 <= sample.cell_index;
        z1   <= sample.measurement;
        in1  <= inside_in;
      end
      idx2  <= idx1;
      in2   <= in1;
      mode2 <= mode1;
      pa2   <= pa1;
      pb2   <= pb1;
      num2  <= num1;
      idx3   <= idx2;
      in3    <= in2;
      mode3  <= mode2;
      blend3 <= sum2[23:16];
      decay3 <= dprod2[32:24];
      if (v3) begin
        out_idx  <= idx3;
        out_cost <= cost3;
      end
    end
  end

  // stage 1 logic
  always_comb begin
    prior1     = in1 ? rd_data : COST_UNKNOWN;
    not_prior1 = COST_UNKNOWN - prior1;
    if (z1 == COST_LETHAL) begin
      mode1 = MODE_BLEND;
      wa1   = cfg.p_occ_given_occ;
      wb1   = cfg.p_occ_given_free_prior;
    end else if (z1 == COST_FREE) begin
      mode1 = MODE_BLEND;
      wa1   = cfg.p_free_given_free;
      wb1   = cfg.p_free_given_occ_prior;
    end else if (z1 == COST_UNKNOWN) begin
      mode1 = MODE_DECAY;
      wa1   = '0;
      wb1   = '0;
    end else begin
      mode1 = MODE_ZERO;
      wa1   = '0;
      wb1   = '0;
    end
    pa1  = {16'b0, prior1} * {8'b0, wa1};
    pb1  = {16'b0, not_prior1} * {8'b0, wb1};
    num1 = {1'b0, prior1, 8'b0} + {1'b0, cfg.decay_bias};
  end

  // stage 2: the blend sum is at most 255 * 65535 and fits 24 bits
  assign sum2   = pa2 + pb2;
  assign dprod2 = {16'b0, num2} * {17'b0, cfg.decay_gain};

  // stage 3
  always_comb begin
    case (mode3)
      MODE_BLEND: est3 = {1'b0, blend3};
      MODE_DECAY: est3 = decay3;
      default:    est3 = '0;
    endcase
    if (est3 < {1'b0, COST_MIN}) begin
      cost3 = COST_MIN;
    end else if (est3 > {1'b0, COST_MAX}) begin
      cost3 = COST_MAX;
    end else begin
      cost3 = est3[COST_W-1:0];
    end
  end

  assign wr.en   = adv && v3 && in3;
  assign wr.addr = ADDR_W'(idx3);
  assign wr.data = cost3;

  assign result.valid    = ov;
  assign result.cell_out = out_idx;
  assign result.new_cost = out_cost;

endmodule

// ===== rtl/ogbu_chk.sv =====
// ----------------------------------------------------------------------------
// ogbu_chk
// Port-level checks for the occupancy grid update, bound to the top level.
// ----------------------------------------------------------------------------
module ogbu_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          sample_ready,
  input logic                          result_valid,
  input logic                          result_ready,
  input logic [ogbu_pkg::IDX_W-1:0]    result_cell_out,
  input logic [ogbu_pkg::COST_W-1:0]   result_new_cost
);
  import ogbu_pkg::*;

  // grid fill runs right after reset
  a_no_take_after_reset: assert property (@(posedge clk)
    rst |=> !sample_ready)
    else $error("measurement taken during grid fill");

  a_cost_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result_new_cost >= COST_MIN && result_new_cost <= COST_MAX))
    else $error("new_cost outside clamp range");

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result beat dropped while stalled");

  a_payload_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> $stable(result_cell_out) && $stable(result_new_cost))
    else $error("result payload changed while stalled");

endmodule

bind occupancy_grid_bayes_update_top ogbu_chk u_chk (
  .clk             (clk),
  .rst             (rst),
  .sample_ready    (sample.ready),
  .result_valid    (result.valid),
  .result_ready    (result.ready),
  .result_cell_out (result.cell_out),
  .result_new_cost (result.new_cost)
);
